// ===== src/sct_pkg.sv =====
package sct_pkg;

  localparam int SCT_OFFSET_BITS = 16;
  localparam logic [15:0] SCT_LEN_MAX = 16'hFFFF;

  // character codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  // keyword mask bits
  localparam int KW_VAR_BIT = 0;
  localparam int KW_FN_BIT  = 1;
  localparam int KW_RET_BIT = 2;
  localparam logic [2:0] KW_ALL = 3'b111;

  typedef enum logic [4:0] {
    TK_VAR    = 5'd0,
    TK_FN     = 5'd1,
    TK_RETURN = 5'd2,
    TK_ADD    = 5'd3,
    TK_SUB    = 5'd4,
    TK_MUL    = 5'd5,
    TK_DIV    = 5'd6,
    TK_SEMI   = 5'd7,
    TK_LPAREN = 5'd8,
    TK_RPAREN = 5'd9,
    TK_LBRACE = 5'd10,
    TK_RBRACE = 5'd11,
    TK_ASSIGN = 5'd12,
    TK_EQ     = 5'd13,
    TK_NOT    = 5'd14,
    TK_NEQ    = 5'd15,
    TK_GT     = 5'd16,
    TK_GTE    = 5'd17,
    TK_LT     = 5'd18,
    TK_LTE    = 5'd19,
    TK_INT    = 5'd20,
    TK_IDENT  = 5'd21
  } tok_kind_t;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_INT    = 3'd1,
    CLS_WORD   = 3'd2,
    CLS_ASSIGN = 3'd3,
    CLS_GT     = 3'd4,
    CLS_LT     = 3'd5,
    CLS_NOT    = 3'd6
  } pend_class_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } sct_token_t;

  typedef struct packed {
    logic [1:0] count;
    sct_token_t tok1;
    sct_token_t tok0;
  } sct_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SCT_LEN_MAX) ? v : v + 16'd1;
  endfunction

  // narrow the keyword mask with character c at run index k
  function automatic logic [2:0] kw_step(input logic [7:0] c, input logic [15:0] k,
                                         input logic [2:0] m);
    logic [2:0] r;
    r = m;
    if (!((k == 16'd0 && c == "v") || (k == 16'd1 && c == "a") ||
          (k == 16'd2 && c == "r")))
      r[KW_VAR_BIT] = 1'b0;
    if (!((k == 16'd0 && c == "f") || (k == 16'd1 && c == "n")))
      r[KW_FN_BIT] = 1'b0;
    if (!((k == 16'd0 && c == "r") || (k == 16'd1 && c == "e") ||
          (k == 16'd2 && c == "t") || (k == 16'd3 && c == "u") ||
          (k == 16'd4 && c == "r") || (k == 16'd5 && c == "n")))
      r[KW_RET_BIT] = 1'b0;
    return r;
  endfunction

  function automatic logic flush_valid(input pend_class_t cls);
    logic v;
    case (cls)
      CLS_INT, CLS_WORD, CLS_ASSIGN, CLS_GT, CLS_LT, CLS_NOT: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic tok_kind_t flush_kind(input pend_class_t cls, input logic [15:0] len,
                                           input logic [2:0] kw);
    tok_kind_t k;
    case (cls)
      CLS_INT: k = TK_INT;
      CLS_WORD: begin
        if (kw[KW_VAR_BIT] && len == 16'd3) k = TK_VAR;
        else if (kw[KW_FN_BIT] && len == 16'd2) k = TK_FN;
        else if (kw[KW_RET_BIT] && len == 16'd6) k = TK_RETURN;
        else k = TK_IDENT;
      end
      CLS_ASSIGN: k = TK_ASSIGN;
      CLS_GT: k = TK_GT;
      CLS_LT: k = TK_LT;
      CLS_NOT: k = TK_NOT;
      default: k = TK_IDENT;
    endcase
    return k;
  endfunction

  function automatic tok_kind_t pair_kind(input pend_class_t cls);
    tok_kind_t k;
    case (cls)
      CLS_ASSIGN: k = TK_EQ;
      CLS_GT: k = TK_GTE;
      CLS_LT: k = TK_LTE;
      default: k = TK_NEQ;
    endcase
    return k;
  endfunction

endpackage

// ===== src/sct_lex.sv =====
module sct_lex import sct_pkg::*; #(
  parameter int OFFSET_BITS = SCT_OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  next_char,
  input  logic        end_of_source,
  output sct_result_t result
);

  logic [OFFSET_BITS-1:0] pos, pos_next;
  pend_class_t            cls, cls_next;
  logic [OFFSET_BITS-1:0] pstart, pstart_next;
  logic [15:0]            plen, plen_next;
  logic [2:0]             kw, kw_next;

  pend_class_t            m_cls;
  logic [OFFSET_BITS-1:0] m_start;
  logic [15:0]            m_len;
  logic [2:0]             m_kw;
  sct_token_t             ca, cb, cc;
  logic                   ca_v, cb_v, cc_v;
  logic                   dig, alp;

  always_comb begin
    dig = is_digit(next_char);
    alp = is_alpha(next_char);
    m_cls = cls;
    m_start = pstart;
    m_len = plen;
    m_kw = kw;
    ca = '{kind: TK_IDENT, start: 16'(pstart), len: plen, last: 1'b0};
    cb = '{kind: TK_ADD, start: 16'(pos), len: 16'd1, last: 1'b0};
    ca_v = 1'b0;
    cb_v = 1'b0;

    if ((cls == CLS_ASSIGN || cls == CLS_GT || cls == CLS_LT || cls == CLS_NOT) &&
        next_char == CH_EQ) begin
      // two-character operator
      ca_v = 1'b1;
      ca.kind = pair_kind(cls);
      ca.len = 16'd2;
      m_cls = CLS_NONE;
      m_len = 16'd0;
    end else if (cls == CLS_INT && dig) begin
      m_len = sat_inc(plen);
    end else if (cls == CLS_WORD && (alp || dig)) begin
      m_kw = kw_step(next_char, plen, kw);
      m_len = sat_inc(plen);
    end else begin
      // flush pending token, then treat the character afresh
      ca_v = flush_valid(cls);
      ca.kind = flush_kind(cls, plen, kw);
      m_cls = CLS_NONE;
      m_len = 16'd0;
      m_kw = KW_ALL;
      case (next_char)
        CH_PLUS:   begin cb_v = 1'b1; cb.kind = TK_ADD;    end
        CH_MINUS:  begin cb_v = 1'b1; cb.kind = TK_SUB;    end
        CH_STAR:   begin cb_v = 1'b1; cb.kind = TK_MUL;    end
        CH_SLASH:  begin cb_v = 1'b1; cb.kind = TK_DIV;    end
        CH_SEMI:   begin cb_v = 1'b1; cb.kind = TK_SEMI;   end
        CH_LPAREN: begin cb_v = 1'b1; cb.kind = TK_LPAREN; end
        CH_RPAREN: begin cb_v = 1'b1; cb.kind = TK_RPAREN; end
        CH_LBRACE: begin cb_v = 1'b1; cb.kind = TK_LBRACE; end
        CH_RBRACE: begin cb_v = 1'b1; cb.kind = TK_RBRACE; end
        CH_EQ:   begin m_cls = CLS_ASSIGN; m_start = pos; m_len = 16'd1; end
        CH_GT:   begin m_cls = CLS_GT;     m_start = pos; m_len = 16'd1; end
        CH_LT:   begin m_cls = CLS_LT;     m_start = pos; m_len = 16'd1; end
        CH_BANG: begin m_cls = CLS_NOT;    m_start = pos; m_len = 16'd1; end
        default: begin
          if (dig) begin
            m_cls = CLS_INT;
            m_start = pos;
            m_len = 16'd1;
          end else if (alp) begin
            m_cls = CLS_WORD;
            m_start = pos;
            m_len = 16'd1;
            m_kw = kw_step(next_char, 16'd0, KW_ALL);
          end
        end
      endcase
    end

    // end of source flushes whatever is left
    cc = '{kind: flush_kind(m_cls, m_len, m_kw), start: 16'(m_start), len: m_len,
           last: 1'b0};
    cc_v = end_of_source && flush_valid(m_cls);

    if (end_of_source) begin
      pos_next = '0;
      pstart_next = '0;
      cls_next = CLS_NONE;
      plen_next = 16'd0;
      kw_next = KW_ALL;
    end else begin
      pos_next = pos + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
      pstart_next = m_start;
      cls_next = m_cls;
      plen_next = m_len;
      kw_next = m_kw;
    end

    // pack into at most two results, flushed token first
    result.tok0 = cc;
    result.tok1 = cc;
    result.count = 2'd0;
    if (ca_v) begin
      result.tok0 = ca;
      result.tok1 = cb_v ? cb : cc;
      result.count = (cb_v || cc_v) ? 2'd2 : 2'd1;
    end else if (cb_v) begin
      result.tok0 = cb;
      result.count = cc_v ? 2'd2 : 2'd1;
    end else if (cc_v) begin
      result.count = 2'd1;
    end
    result.tok0.last = (result.count == 2'd1);
    result.tok1.last = 1'b1;
    if (!accept) result.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cls <= CLS_NONE;
      pstart <= '0;
      plen <= 16'd0;
      kw <= KW_ALL;
    end else if (accept) begin
      pos <= pos_next;
      cls <= cls_next;
      pstart <= pstart_next;
      plen <= plen_next;
      kw <= kw_next;
    end
  end

endmodule

// ===== src/source_char_tokenizer.sv =====
// channel   | direction | tdata                                | tuser      | tlast
// s_axis    | in        | [7:0] next_char                      | -          | end_of_source
// m_axis    | out       | [15:0] token_start, [31:16] token_len | token_kind | last_in_run
//
// one source byte is taken per cycle while s_axis_tready is high; the tokenizer step
// is a single combinational pass from the lexer state registers into a four-entry
// result queue; a byte yields zero, one or two tokens; the queue drains one token
// per cycle while m_axis_tready is high, and input stalls only when the queue holds
// more than two tokens (s_axis_tready comes straight from the queue count)
// synchronous active-high reset clears the lexer state and empties the queue
module source_char_tokenizer import sct_pkg::*; #(
  parameter int OFFSET_BITS = SCT_OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] next_char
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length
  output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
  output logic        m_axis_tlast    // last_in_run
);

  localparam int QDEPTH = 4;
  localparam int QPTR   = $clog2(QDEPTH);

  logic        in_xfer, out_xfer;
  sct_result_t res;

  // result queue
  sct_token_t      q [QDEPTH];
  logic [QPTR-1:0] wr_ptr, rd_ptr;
  logic [QPTR:0]   count, count_next;
  sct_token_t      head;

  // room for two more tokens before a byte is taken
  assign s_axis_tready = (count <= (QPTR+1)'(QDEPTH - 2));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  sct_lex #(.OFFSET_BITS(OFFSET_BITS)) u_lex (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_xfer),
    .next_char     (s_axis_tdata),
    .end_of_source (s_axis_tlast),
    .result        (res)
  );

  always_comb begin
    count_next = count + (QPTR+1)'(res.count) - (QPTR+1)'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR'(res.count);
      if (out_xfer) rd_ptr <= rd_ptr + QPTR'(1);
      count <= count_next;
    end
  end

  // token storage, up to two writes per transfer
  always_ff @(posedge clk) begin
    if (res.count != 2'd0) q[wr_ptr] <= res.tok0;
    if (res.count == 2'd2) q[wr_ptr + QPTR'(1)] <= res.tok1;
  end

  assign head          = q[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {head.len, head.start};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

endmodule
